// ----- rtl/dmbs_pkg.sv -----
// ----------------------------------------------------------------------------
// dmbs_pkg: shared types and constants for the best display mode selector
// Aspect ratio tables, score constants, request and register index codes.
// ----------------------------------------------------------------------------
package dmbs_pkg;

	localparam int FPS_W   = 24;
	localparam int DIM_W   = 13;
	localparam int RATE_W  = 8;
	localparam int CODE_W  = 8;
	localparam int SCORE_W = 31;
	localparam int QDEPTH_DEFAULT = 4;

	localparam logic [SCORE_W-1:0] SCORE_BOUND = SCORE_W'(1) << 30;

	typedef enum logic [1:0] {
		REG_TARGET_FPS    = 2'd0,
		REG_TARGET_WIDTH  = 2'd1,
		REG_TARGET_HEIGHT = 2'd2,
		REG_NONE          = 2'd3
	} reg_idx_t;

	// classified request handed from front to back
	typedef struct packed {
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [RATE_W-1:0]  rate;
		logic               is_native;
		logic [2:0]         aspect_code;
		logic [CODE_W-1:0]  mode_code;
		logic               last_mode;
		logic [1:0]         rate_class;
	} req_t;

	typedef enum logic [1:0] {
		RC_EXACT  = 2'd0,
		RC_DOUBLE = 2'd1,
		RC_OTHER  = 2'd2,
		RC_ZERO   = 2'd3
	} rate_class_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDIV,
		ST_ADIV,
		ST_SUM,
		ST_OUT
	} bst_t;

	function automatic logic [6:0] aspect_num(input logic [2:0] c);
		case (c)
			3'd0: aspect_num = 7'd4;
			3'd1: aspect_num = 7'd14;
			3'd2: aspect_num = 7'd16;
			3'd3: aspect_num = 7'd5;
			3'd4: aspect_num = 7'd16;
			3'd5: aspect_num = 7'd15;
			3'd6: aspect_num = 7'd64;
			default: aspect_num = 7'd16;
		endcase
	endfunction

	function automatic logic [4:0] aspect_den(input logic [2:0] c);
		case (c)
			3'd0: aspect_den = 5'd3;
			3'd1: aspect_den = 5'd9;
			3'd2: aspect_den = 5'd9;
			3'd3: aspect_den = 5'd4;
			3'd4: aspect_den = 5'd10;
			3'd5: aspect_den = 5'd9;
			3'd6: aspect_den = 5'd27;
			default: aspect_den = 5'd9;
		endcase
	endfunction

endpackage

// ----- rtl/dmbs_ram.sv -----
// ----------------------------------------------------------------------------
// dmbs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dmbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/dmbs_front.sv -----
// ----------------------------------------------------------------------------
// dmbs_front: request intake and rate classification
// Registers each accepted mode with its rate match class.
// ----------------------------------------------------------------------------
module dmbs_front import dmbs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [DIM_W-1:0]  mode_width,
	input  logic [DIM_W-1:0]  mode_height,
	input  logic [RATE_W-1:0] mode_rate,
	input  logic              is_native,
	input  logic [2:0]        aspect_code,
	input  logic [CODE_W-1:0] mode_code,
	input  logic              last_mode,
	input  logic [FPS_W-1:0]  target_fps,
	output logic              req_valid,
	input  logic              req_ready,
	output req_t              req
);
	logic        valid_s1;
	req_t        req_s1;
	logic [24:0] rq;
	logic [25:0] f2;
	logic [24:0] d1;
	logic [25:0] d2;
	logic [34:0] m1, m2;
	logic [1:0]  cls;

	assign full = valid_s1 && !req_ready;

	always_comb begin
		rq = {1'b0, mode_rate, 16'd0};
		f2 = {1'b0, target_fps, 1'b0};
		d1 = (rq > 25'(target_fps)) ? rq - 25'(target_fps) : 25'(target_fps) - rq;
		d2 = (26'(rq) > f2) ? 26'(rq) - f2 : f2 - 26'(rq);
		m1 = 35'(d1) * 35'd500;
		m2 = 35'(d2) * 35'd500;
		if (m1 < 35'(target_fps))      cls = RC_EXACT;
		else if (m2 < 35'(target_fps)) cls = RC_DOUBLE;
		else if (mode_rate == '0)      cls = RC_ZERO;
		else                           cls = RC_OTHER;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			req_s1 <= '{mode_width, mode_height, mode_rate, is_native, aspect_code,
				mode_code, last_mode, cls};
		end
	end

	assign req_valid = valid_s1;
	assign req       = req_s1;
endmodule

// ----- rtl/dmbs_queue.sv -----
// ----------------------------------------------------------------------------
// dmbs_queue: short FIFO between front and back
// Storage in a generic RAM with registered read; a head register keeps
// the oldest entry visible.
// ----------------------------------------------------------------------------
module dmbs_queue import dmbs_pkg::*; #(
	parameter int DEPTH = QDEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_req,
	output logic out_valid,
	input  logic out_ready,
	output req_t out_req
);
	localparam int AW = $clog2(DEPTH);

	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;     // entries in RAM
	logic          hv_q;      // head register valid
	logic          rd_pend_q; // RAM read in flight to head
	req_t          rdata;
	req_t          head_q;
	logic          wr, rd, head_take, head_free;

	assign in_ready  = cnt_q != (AW+1)'(DEPTH);
	assign wr        = in_valid && in_ready;
	assign head_take = hv_q && out_ready;
	assign head_free = (!hv_q || head_take) && !rd_pend_q;
	assign rd        = head_free && cnt_q != '0;

	dmbs_ram #(.WIDTH($bits(req_t)), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(wr), .waddr(wp_q), .wdata(in_req),
		.raddr(rp_q), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
			hv_q <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
			rd_pend_q <= rd;
			if (rd_pend_q)      hv_q <= 1'b1;
			else if (head_take) hv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_q) head_q <= rdata;
	end

	assign out_valid = hv_q;
	assign out_req   = head_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> !hv_q || $past(out_ready))
		else $error("head overwritten while held");
endmodule

// ----- rtl/dmbs_div.sv -----
// ----------------------------------------------------------------------------
// dmbs_div: radix-2 restoring divider
// One quotient bit per cycle, shared for the rate and aspect terms.
// ----------------------------------------------------------------------------
module dmbs_div #(
	parameter int NW = 33,
	parameter int DW = 18
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW+1);

	logic [NW-1:0] q_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] n_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;

	assign trial = {r_q[DW-1:0], q_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			n_q <= '0;
			done_q <= 1'b0;
		end else begin
			// pulse in the same cycle as the last quotient bit lands
			done_q <= busy_q && n_q == CW'(1);
			if (start) begin
				busy_q <= 1'b1;
				n_q <= CW'(NW);
			end else if (busy_q) begin
				n_q <= n_q - 1'b1;
				if (n_q == CW'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, d_q}) begin
				r_q <= trial - {1'b0, d_q};
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = q_q;
endmodule

// ----- rtl/dmbs_back.sv -----
// ----------------------------------------------------------------------------
// dmbs_back: scoring sequencer and best-mode tracking
// Runs up to two divisions on a shared divider, adds the score terms, keeps
// the first lowest score and emits the result on the last mode.
// ----------------------------------------------------------------------------
module dmbs_back import dmbs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  req_t               req,
	input  logic [FPS_W-1:0]   target_fps,
	input  logic [DIM_W-1:0]   target_width,
	input  logic [DIM_W-1:0]   target_height,
	output logic               empty,
	input  logic               pop,
	output logic               mode_found,
	output logic [CODE_W-1:0]  best_code,
	output logic [SCORE_W-1:0] win_score,
	output logic               ntsc_rate
);
	localparam int NW = 33;
	localparam int DW = 18;

	bst_t st_q, st_d;
	req_t cur_q;
	logic [SCORE_W-1:0] rterm_q, aterm_q, rest_q;
	logic [SCORE_W-1:0] low_q;
	logic [CODE_W-1:0]  lcode_q;
	logic               found_q;
	logic               ov_q;
	logic               ofound_q, ontsc_q;
	logic [CODE_W-1:0]  ocode_q;
	logic [SCORE_W-1:0] oscore_q;

	logic          dstart, ddone;
	logic [NW-1:0] dnum, dquo;
	logic [DW-1:0] dden;

	logic [17:0] dw;
	logic [20:0] nh;
	logic [20:0] adiff;
	logic [SCORE_W-1:0] rest_d, total;
	logic [8:0]  ti;
	logic [33:0] base, fn, fp;
	logic [33:0] dn, dp;

	dmbs_div #(.NW(NW), .DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(dden),
		.done(ddone), .quo(dquo)
	);

	// aspect operands and the non-division terms of the current request
	always_comb begin
		dw    = 18'(aspect_den(cur_q.aspect_code)) * 18'(cur_q.width);
		nh    = 21'(aspect_num(cur_q.aspect_code)) * 21'(cur_q.height);
		adiff = (nh > 21'(dw)) ? nh - 21'(dw) : 21'(dw) - nh;
		rest_d = cur_q.is_native ? '0 : SCORE_W'(65536);
		if (target_width != '0 && target_height != '0) begin
			if (target_width > cur_q.width)
				rest_d += SCORE_W'(target_width - cur_q.width) << 16;
			else
				rest_d += SCORE_W'(cur_q.width - target_width) << 4;
			if (target_height > cur_q.height)
				rest_d += SCORE_W'(target_height - cur_q.height) << 16;
			else
				rest_d += SCORE_W'(cur_q.height - target_height) << 4;
		end
	end

	assign total = rterm_q + aterm_q + rest_q;

	// NTSC flag from the target rate alone; rounded rate reaches 256
	always_comb begin
		ti   = 9'((25'(target_fps) + 25'd32768) >> 16);
		base = 34'(ti) * 34'd65536000;
		fn   = 34'(target_fps) * 34'd1001;
		fp   = 34'(target_fps) * 34'd1000;
		dn   = (fn > base) ? fn - base : base - fn;
		dp   = (fp > base) ? fp - base : base - fp;
	end

	always_comb begin
		st_d = st_q;
		dstart = 1'b0;
		dnum = '0;
		dden = '0;
		req_ready = 1'b0;
		case (st_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) st_d = ST_RDIV;
			end
			ST_RDIV: begin
				if (cur_q.rate_class == RC_OTHER) begin
					dstart = 1'b1;
					dnum = NW'(1) << 20;
					dden = DW'(cur_q.rate);
				end
				st_d = ST_ADIV;
			end
			ST_ADIV: begin
				if (cur_q.rate_class != RC_OTHER || ddone) begin
					if (cur_q.width != '0) begin
						dstart = 1'b1;
						dnum = NW'(adiff) << 12;
						dden = dw;
					end
					st_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (cur_q.width == '0 || ddone) st_d = ST_OUT;
			end
			ST_OUT: begin
				if (!cur_q.last_mode || !ov_q || pop) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			low_q <= SCORE_BOUND;
			lcode_q <= '0;
			found_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_OUT && st_d == ST_IDLE && cur_q.last_mode)
				ov_q <= 1'b1;
			else if (ov_q && pop)
				ov_q <= 1'b0;
			if (st_q == ST_OUT && st_d == ST_IDLE) begin
				if (cur_q.last_mode) begin
					low_q <= SCORE_BOUND;
					lcode_q <= '0;
					found_q <= 1'b0;
				end else if (total < low_q) begin
					low_q <= total;
					lcode_q <= cur_q.mode_code;
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && req_valid) cur_q <= req;
		if (st_q == ST_RDIV) begin
			rest_q <= rest_d;
			case (cur_q.rate_class)
				RC_EXACT:  rterm_q <= '0;
				RC_DOUBLE: rterm_q <= SCORE_W'(256);
				RC_ZERO:   rterm_q <= SCORE_W'(65536) + (SCORE_W'(1) << 20);
				default:   rterm_q <= '0;
			endcase
		end
		if (st_q == ST_ADIV && ddone) rterm_q <= SCORE_W'(65536) + SCORE_W'(dquo);
		if (st_q == ST_ADIV && cur_q.width == '0) aterm_q <= SCORE_W'(1) << 20;
		if (st_q == ST_SUM && ddone) aterm_q <= SCORE_W'(dquo);
		if (st_q == ST_OUT && st_d == ST_IDLE && cur_q.last_mode) begin
			if (total < low_q) begin
				ofound_q <= 1'b1;
				ocode_q <= cur_q.mode_code;
				oscore_q <= total;
			end else begin
				ofound_q <= found_q;
				ocode_q <= lcode_q;
				oscore_q <= low_q;
			end
			ontsc_q <= dn < dp;
		end
	end

	assign empty      = !ov_q;
	assign mode_found = ofound_q;
	assign best_code  = ocode_q;
	assign win_score  = oscore_q;
	assign ntsc_rate  = ontsc_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		low_q <= SCORE_BOUND)
		else $error("lowest score above bound");
	assert property (@(posedge clk) disable iff (!arst_n)
		!found_q |-> low_q == SCORE_BOUND)
		else $error("score kept without a found mode");
	assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !pop) |=> ov_q && $stable(win_score))
		else $error("pending result lost");
endmodule

// ----- rtl/display_mode_best_score_select.sv -----
// ----------------------------------------------------------------------------
// display_mode_best_score_select: best display mode selector
// Scores candidate modes against a target rate and size, reports the best.
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// input    | push / full        | mode_width..last_mode
// result   | empty / pop        | mode_found, best_code, win_score, ntsc_rate
// config   | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// In the back end, a mode takes up to two passes of the shared serial divider
// (rate, then aspect term) plus accept, setup and update. An exact or double
// rate match or a zero rate skips the rate pass; zero width skips the aspect
// pass. The front registers each mode; the queue absorbs short bursts.
// Reset clears the search (bound 2^30) and the registers to zero.
// A result waiting to be popped stalls only the last mode of the next list.
// ----------------------------------------------------------------------------
module display_mode_best_score_select import dmbs_pkg::*; #(
	parameter int QDEPTH = QDEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [DIM_W-1:0]   mode_width,
	input  logic [DIM_W-1:0]   mode_height,
	input  logic [RATE_W-1:0]  mode_rate,
	input  logic               is_native,
	input  logic [2:0]         aspect_code,
	input  logic [CODE_W-1:0]  mode_code,
	input  logic               last_mode,
	output logic               empty,
	input  logic               pop,
	output logic               mode_found,
	output logic [CODE_W-1:0]  best_code,
	output logic [SCORE_W-1:0] win_score,
	output logic               ntsc_rate,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [FPS_W-1:0]   cfg_data
);
	logic [FPS_W-1:0] fps_q;
	logic [DIM_W-1:0] tw_q, th_q;
	logic fq_valid, fq_ready, qb_valid, qb_ready;
	req_t fq_req, qb_req;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fps_q <= '0;
			tw_q <= '0;
			th_q <= '0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_TARGET_FPS:    fps_q <= cfg_data;
				REG_TARGET_WIDTH:  tw_q <= cfg_data[DIM_W-1:0];
				REG_TARGET_HEIGHT: th_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	dmbs_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.mode_width(mode_width), .mode_height(mode_height), .mode_rate(mode_rate),
		.is_native(is_native), .aspect_code(aspect_code), .mode_code(mode_code),
		.last_mode(last_mode), .target_fps(fps_q),
		.req_valid(fq_valid), .req_ready(fq_ready), .req(fq_req)
	);

	dmbs_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .in_valid(fq_valid), .in_ready(fq_ready),
		.in_req(fq_req), .out_valid(qb_valid), .out_ready(qb_ready), .out_req(qb_req)
	);

	dmbs_back u_back (
		.clk(clk), .arst_n(arst_n), .req_valid(qb_valid), .req_ready(qb_ready),
		.req(qb_req), .target_fps(fps_q), .target_width(tw_q), .target_height(th_q),
		.empty(empty), .pop(pop), .mode_found(mode_found), .best_code(best_code),
		.win_score(win_score), .ntsc_rate(ntsc_rate)
	);
endmodule
